// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl module rtns_ctrl
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTNS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define RTNS_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition");
`else
`define RTNS_ASSERT(lbl, clk, rstn, prop)
`define RTNS_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ===== sv/rtns_pkg.sv =====
// shared types and constants for the radix tree node split core
// no dependencies
package rtns_pkg;

  localparam int IDX_W = 10;
  localparam int ID_W = 10;
  localparam int CNT_W = 11;
  localparam int CODE_IN_W = 32;
  localparam int ID_PFX_W = 32;
  localparam int LMAX_INIT = 128;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_NODE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_I_RD, ST_I_EV, ST_PREV_RD, ST_PREV_EV,
    ST_NEXT_RD, ST_NEXT_EV, ST_EXP_RD, ST_EXP_EV, ST_BIN_RD, ST_BIN_EV,
    ST_J_RD, ST_J_EV, ST_SPL_RD, ST_SPL_EV, ST_DONE, ST_BAD
  } state_t;

  typedef enum logic [2:0] {
    SRC_NONE, SRC_I, SRC_PREV, SRC_NEXT, SRC_EXP, SRC_BIN, SRC_J, SRC_SPL
  } src_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_LOADI, ACT_PREV, ACT_NEXT, ACT_EXP, ACT_BIN, ACT_J, ACT_SPL
  } act_t;

  typedef struct packed {
    logic load;
    logic capture;
    src_t src;
    act_t act;
    logic fin_ok;
    logic fin_bad;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic gt_dmin;
    logic t_le1;
  } sts_t;

endpackage

// ===== sv/rtns_ctrl.sv =====
// sequencer for the node split search
// depends on rtns_pkg and assert_macros.svh
`include "assert_macros.svh"
module rtns_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_func,
  input  rtns_pkg::sts_t sts,
  output rtns_pkg::cmd_t cmd,
  output logic          busy
);

  rtns_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtns_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rtns_pkg::ST_IDLE:    if (start && in_func) state_nxt = rtns_pkg::ST_CHECK;
      rtns_pkg::ST_CHECK:   state_nxt = sts.bad ? rtns_pkg::ST_BAD : rtns_pkg::ST_I_RD;
      rtns_pkg::ST_I_RD:    state_nxt = rtns_pkg::ST_I_EV;
      rtns_pkg::ST_I_EV:    state_nxt = rtns_pkg::ST_PREV_RD;
      rtns_pkg::ST_PREV_RD: state_nxt = rtns_pkg::ST_PREV_EV;
      rtns_pkg::ST_PREV_EV: state_nxt = rtns_pkg::ST_NEXT_RD;
      rtns_pkg::ST_NEXT_RD: state_nxt = rtns_pkg::ST_NEXT_EV;
      rtns_pkg::ST_NEXT_EV: state_nxt = rtns_pkg::ST_EXP_RD;
      rtns_pkg::ST_EXP_RD:  state_nxt = rtns_pkg::ST_EXP_EV;
      rtns_pkg::ST_EXP_EV:
        state_nxt = sts.gt_dmin ? rtns_pkg::ST_EXP_RD : rtns_pkg::ST_BIN_RD;
      rtns_pkg::ST_BIN_RD:  state_nxt = rtns_pkg::ST_BIN_EV;
      rtns_pkg::ST_BIN_EV:
        state_nxt = sts.t_le1 ? rtns_pkg::ST_J_RD : rtns_pkg::ST_BIN_RD;
      rtns_pkg::ST_J_RD:    state_nxt = rtns_pkg::ST_J_EV;
      rtns_pkg::ST_J_EV:    state_nxt = rtns_pkg::ST_SPL_RD;
      rtns_pkg::ST_SPL_RD:  state_nxt = rtns_pkg::ST_SPL_EV;
      rtns_pkg::ST_SPL_EV:
        state_nxt = sts.t_le1 ? rtns_pkg::ST_DONE : rtns_pkg::ST_SPL_RD;
      rtns_pkg::ST_DONE:    state_nxt = rtns_pkg::ST_IDLE;
      rtns_pkg::ST_BAD:     state_nxt = rtns_pkg::ST_IDLE;
      default:              state_nxt = rtns_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{load: 1'b0, capture: 1'b0, src: rtns_pkg::SRC_NONE,
            act: rtns_pkg::ACT_NONE, fin_ok: 1'b0, fin_bad: 1'b0};
    case (state_r)
      rtns_pkg::ST_IDLE: begin
        cmd.load    = start && !in_func;
        cmd.capture = start && in_func;
      end
      rtns_pkg::ST_I_RD:    cmd.src = rtns_pkg::SRC_I;
      rtns_pkg::ST_I_EV:    cmd.act = rtns_pkg::ACT_LOADI;
      rtns_pkg::ST_PREV_RD: cmd.src = rtns_pkg::SRC_PREV;
      rtns_pkg::ST_PREV_EV: cmd.act = rtns_pkg::ACT_PREV;
      rtns_pkg::ST_NEXT_RD: cmd.src = rtns_pkg::SRC_NEXT;
      rtns_pkg::ST_NEXT_EV: cmd.act = rtns_pkg::ACT_NEXT;
      rtns_pkg::ST_EXP_RD:  cmd.src = rtns_pkg::SRC_EXP;
      rtns_pkg::ST_EXP_EV:  cmd.act = rtns_pkg::ACT_EXP;
      rtns_pkg::ST_BIN_RD:  cmd.src = rtns_pkg::SRC_BIN;
      rtns_pkg::ST_BIN_EV:  cmd.act = rtns_pkg::ACT_BIN;
      rtns_pkg::ST_J_RD:    cmd.src = rtns_pkg::SRC_J;
      rtns_pkg::ST_J_EV:    cmd.act = rtns_pkg::ACT_J;
      rtns_pkg::ST_SPL_RD:  cmd.src = rtns_pkg::SRC_SPL;
      rtns_pkg::ST_SPL_EV:  cmd.act = rtns_pkg::ACT_SPL;
      rtns_pkg::ST_DONE:    cmd.fin_ok = 1'b1;
      rtns_pkg::ST_BAD:     cmd.fin_bad = 1'b1;
      default:              cmd.fin_bad = 1'b0;
    endcase
  end

  assign busy = (state_r != rtns_pkg::ST_IDLE);

  `RTNS_ASSERT(a_fin_to_idle, clk, rst_n, (cmd.fin_ok || cmd.fin_bad) |=> !busy)
  `RTNS_NEVER(a_fin_excl, clk, rst_n, cmd.fin_ok && cmd.fin_bad)
  `RTNS_ASSERT(a_start_check, clk, rst_n,
    (!busy && start && in_func) |=> (state_r == rtns_pkg::ST_CHECK))
  `RTNS_NEVER(a_load_busy, clk, rst_n, cmd.load && busy)

endmodule

// ===== sv/rtns_datapath.sv =====
// leaf store, prefix compare and search registers of the node split core
// depends on rtns_pkg
module rtns_datapath #(
  parameter int MAX_LEAVES = 1024,
  parameter int CODE_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rtns_pkg::cmd_t                cmd,
  output rtns_pkg::sts_t                sts,
  input  logic [rtns_pkg::IDX_W-1:0]    in_index,
  input  logic [rtns_pkg::CODE_IN_W-1:0] in_leaf_code,
  input  logic [rtns_pkg::ID_W-1:0]     in_leaf_id,
  input  logic                          cfg_we,
  input  logic [rtns_pkg::CNT_W-1:0]    cfg_data,
  output logic                          out_valid,
  output logic [rtns_pkg::IDX_W-1:0]    out_node_index,
  output logic [rtns_pkg::IDX_W-1:0]    out_left_child,
  output logic                          out_left_is_leaf,
  output logic [rtns_pkg::IDX_W-1:0]    out_right_child,
  output logic                          out_right_is_leaf,
  output logic                          out_bad_node
);

  localparam int LW  = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
  localparam int PW  = LW + 12;
  localparam int PFW = $clog2(CODE_BITS + 33) + 1;

  logic [CODE_BITS-1:0]       mem_code [MAX_LEAVES];
  logic [rtns_pkg::ID_W-1:0]  mem_id   [MAX_LEAVES];

  logic [rtns_pkg::CNT_W-1:0] leaf_count_r;
  logic [rtns_pkg::IDX_W-1:0] idx_r;
  logic signed [PW-1:0]       i_r, n_r, lmax_r, l_r, t_r, s_r;
  logic signed [PFW-1:0]      dprev_r, dmin_r, dnode_r;
  logic                       d_neg_r, rd_ok_r;
  logic [CODE_BITS-1:0]       code_i_r, rd_code_r;
  logic [rtns_pkg::ID_W-1:0]  id_i_r, rd_id_r;
  logic                       out_valid_r;

  logic signed [PW-1:0]       widx, lc, n_nxt, off, p, k, j, lo, hi, k1;
  logic                       neg, p_ok;
  logic [CODE_BITS-1:0]       wcode;
  logic signed [PFW-1:0]      pfx;
  logic [PFW-1:0]             lz_c, lz_i;

  function automatic logic [PFW-1:0] lzc_code(input logic [CODE_BITS-1:0] x);
    logic [PFW-1:0] n;
    n = PFW'(CODE_BITS);
    for (int b = 0; b < CODE_BITS; b++) begin
      if (x[b]) n = PFW'(CODE_BITS - 1 - b);
    end
    return n;
  endfunction

  function automatic logic [PFW-1:0] lzc_id(input logic [rtns_pkg::ID_W-1:0] x);
    logic [PFW-1:0] n;
    n = PFW'(rtns_pkg::ID_W);
    for (int b = 0; b < rtns_pkg::ID_W; b++) begin
      if (x[b]) n = PFW'(rtns_pkg::ID_W - 1 - b);
    end
    return n;
  endfunction

  always_comb begin
    widx  = $signed({{(PW-rtns_pkg::IDX_W){1'b0}}, in_index});
    lc    = $signed({{(PW-rtns_pkg::CNT_W){1'b0}}, leaf_count_r});
    n_nxt = (lc > PW'(MAX_LEAVES)) ? PW'(MAX_LEAVES) : lc;
    for (int b = 0; b < CODE_BITS; b++) begin
      wcode[b] = (b < rtns_pkg::CODE_IN_W) ? in_leaf_code[b] : 1'b0;
    end
  end

  // probe address
  always_comb begin
    neg = d_neg_r;
    case (cmd.src)
      rtns_pkg::SRC_I: begin
        off = '0;
        neg = 1'b0;
      end
      rtns_pkg::SRC_PREV: begin
        off = PW'(1);
        neg = 1'b1;
      end
      rtns_pkg::SRC_NEXT: begin
        off = PW'(1);
        neg = 1'b0;
      end
      rtns_pkg::SRC_EXP: off = lmax_r;
      rtns_pkg::SRC_BIN: off = l_r + t_r;
      rtns_pkg::SRC_J:   off = l_r;
      rtns_pkg::SRC_SPL: off = s_r + t_r;
      default:           off = '0;
    endcase
    p    = neg ? (i_r - off) : (i_r + off);
    p_ok = (p >= PW'(0)) && (p < n_r);
  end

  // common prefix with code and id tie-break
  always_comb begin
    lz_c = lzc_code(code_i_r ^ rd_code_r);
    lz_i = lzc_id(id_i_r ^ rd_id_r);
    if (!rd_ok_r) begin
      pfx = -PFW'(1);
    end else if (lz_c == PFW'(CODE_BITS)) begin
      pfx = $signed(lz_c + PFW'(rtns_pkg::ID_PFX_W - rtns_pkg::ID_W) + lz_i);
    end else begin
      pfx = $signed(lz_c);
    end
  end

  assign sts.bad     = (n_r < PW'(2)) || (i_r >= n_r - PW'(1));
  assign sts.gt_dmin = (pfx > dmin_r);
  assign sts.t_le1   = (t_r <= PW'(1));

  always_comb begin
    j  = d_neg_r ? (i_r - l_r) : (i_r + l_r);
    k  = d_neg_r ? (i_r - s_r - PW'(1)) : (i_r + s_r);
    k1 = k + PW'(1);
    lo = (i_r < j) ? i_r : j;
    hi = (i_r < j) ? j : i_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (widx < PW'(MAX_LEAVES))) begin
      mem_code[widx[LW-1:0]] <= wcode;
      mem_id[widx[LW-1:0]]   <= in_leaf_id;
    end else if (cmd.src != rtns_pkg::SRC_NONE) begin
      rd_code_r <= mem_code[p[LW-1:0]];
      rd_id_r   <= mem_id[p[LW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_count_r <= rtns_pkg::CNT_W'(2);
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) leaf_count_r <= cfg_data;
      out_valid_r <= cmd.fin_ok || cmd.fin_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r <= in_index;
      i_r   <= widx;
      n_r   <= n_nxt;
    end
    if (cmd.src != rtns_pkg::SRC_NONE) rd_ok_r <= p_ok;
    case (cmd.act)
      rtns_pkg::ACT_LOADI: begin
        code_i_r <= rd_code_r;
        id_i_r   <= rd_id_r;
      end
      rtns_pkg::ACT_PREV: dprev_r <= pfx;
      rtns_pkg::ACT_NEXT: begin
        dmin_r  <= (dprev_r < pfx) ? dprev_r : pfx;
        d_neg_r <= !(pfx > dprev_r);
        lmax_r  <= PW'(rtns_pkg::LMAX_INIT);
      end
      rtns_pkg::ACT_EXP: begin
        if (pfx > dmin_r) begin
          lmax_r <= lmax_r <<< 2;
        end else begin
          l_r <= '0;
          t_r <= lmax_r >>> 1;
        end
      end
      rtns_pkg::ACT_BIN: begin
        if (pfx > dmin_r) l_r <= l_r + t_r;
        t_r <= t_r >>> 1;
      end
      rtns_pkg::ACT_J: begin
        dnode_r <= pfx;
        s_r     <= '0;
        t_r     <= (l_r + PW'(1)) >>> 1;
      end
      rtns_pkg::ACT_SPL: begin
        if (pfx > dnode_r) s_r <= s_r + t_r;
        if (t_r > PW'(1)) t_r <= (t_r + PW'(1)) >>> 1;
      end
      default: begin
      end
    endcase
    if (cmd.fin_ok) begin
      out_node_index    <= idx_r;
      out_left_child    <= k[rtns_pkg::IDX_W-1:0];
      out_left_is_leaf  <= (lo == k);
      out_right_child   <= k1[rtns_pkg::IDX_W-1:0];
      out_right_is_leaf <= (hi == k1);
      out_bad_node      <= 1'b0;
    end else if (cmd.fin_bad) begin
      out_node_index    <= idx_r;
      out_left_child    <= '0;
      out_left_is_leaf  <= 1'b0;
      out_right_child   <= '0;
      out_right_is_leaf <= 1'b0;
      out_bad_node      <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/radix_tree_node_split_core.sv =====
// a load is written to the store from idle; a node item passes a check state, then reads
// the store for i, i-1, i+1 and the exponential, binary, j and split probes, each probe
// having a read and an evaluate state, and ends in a done state; a bad node goes from
// check to a bad state; busy is high out of idle; one item is worked at a time; results cannot be stalled
// synchronous active-low reset clears control and sets leaf_count to 2; stores keep no reset
// top level: joins rtns_ctrl and rtns_datapath, depends on rtns_pkg
module radix_tree_node_split_core #(
  parameter int MAX_LEAVES = 1024,
  parameter int CODE_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_func,
  input  logic [rtns_pkg::IDX_W-1:0]     in_index,
  input  logic [rtns_pkg::CODE_IN_W-1:0] in_leaf_code,
  input  logic [rtns_pkg::ID_W-1:0]      in_leaf_id,
  input  logic                           cfg_we,
  input  logic [rtns_pkg::CNT_W-1:0]     cfg_data,
  output logic                           out_valid,
  output logic [rtns_pkg::IDX_W-1:0]     out_node_index,
  output logic [rtns_pkg::IDX_W-1:0]     out_left_child,
  output logic                           out_left_is_leaf,
  output logic [rtns_pkg::IDX_W-1:0]     out_right_child,
  output logic                           out_right_is_leaf,
  output logic                           out_bad_node
);

  rtns_pkg::cmd_t cmd;
  rtns_pkg::sts_t sts;

  rtns_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  rtns_datapath #(
    .MAX_LEAVES (MAX_LEAVES),
    .CODE_BITS  (CODE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_index          (in_index),
    .in_leaf_code      (in_leaf_code),
    .in_leaf_id        (in_leaf_id),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_node_index    (out_node_index),
    .out_left_child    (out_left_child),
    .out_left_is_leaf  (out_left_is_leaf),
    .out_right_child   (out_right_child),
    .out_right_is_leaf (out_right_is_leaf),
    .out_bad_node      (out_bad_node)
  );

endmodule

// ===== tb/sv/rtns_checker.sv =====
// checker for radix_tree_node_split_core: tracks the leaf stores and leaf_count,
// predicts each node item's children and compares them with the result port
// depends on rtns_pkg
module rtns_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           in_func,
  input  logic [rtns_pkg::IDX_W-1:0]     in_index,
  input  logic [rtns_pkg::CODE_IN_W-1:0] in_leaf_code,
  input  logic [rtns_pkg::ID_W-1:0]      in_leaf_id,
  input  logic                           cfg_we,
  input  logic [rtns_pkg::CNT_W-1:0]     cfg_data,
  input  logic                           out_valid,
  input  logic [rtns_pkg::IDX_W-1:0]     out_node_index,
  input  logic [rtns_pkg::IDX_W-1:0]     out_left_child,
  input  logic                           out_left_is_leaf,
  input  logic [rtns_pkg::IDX_W-1:0]     out_right_child,
  input  logic                           out_right_is_leaf,
  input  logic                           out_bad_node,
  output int                             err_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rtns_pkg::*;

  localparam int LEAVES = 1024;

  typedef struct packed {
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] left;
    logic             left_leaf;
    logic [IDX_W-1:0] right;
    logic             right_leaf;
    logic             bad;
  } split_t;

  logic [31:0]     codes [LEAVES];
  logic [ID_W-1:0] ids   [LEAVES];
  logic [CNT_W-1:0] leaf_cnt;
  split_t split_q[$];

  function automatic int lead0(logic [31:0] x);
    int k;
    k = 0;
    for (int b = 31; b >= 0; b--) begin
      if (x[b]) break;
      k++;
    end
    return k;
  endfunction

  function automatic int common_len(longint a, longint b, int n);
    int bits;
    if (b < 0 || b >= n || a < 0 || a >= n) return -1;
    bits = lead0(codes[a] ^ codes[b]);
    if (bits == 32) bits += lead0(32'(ids[a] ^ ids[b]));
    return bits;
  endfunction

  function automatic split_t split_node(logic [IDX_W-1:0] idx);
    split_t r;
    int n, dprev, dnext, dmin, dnode, d;
    longint i, lmax, l, t, s, j, k, lo, hi, probe;
    r = '0;
    r.node = idx;
    n = (leaf_cnt > LEAVES) ? LEAVES : int'(leaf_cnt);
    if (n < 2 || longint'(idx) >= n - 1) begin
      r.bad = 1'b1;
      return r;
    end
    i = idx;
    dprev = common_len(i, i - 1, n);
    dnext = common_len(i, i + 1, n);
    dmin = dprev < dnext ? dprev : dnext;
    d = dnext > dprev ? 1 : -1;
    lmax = 32;
    do begin
      lmax = lmax << 2;
      probe = i + lmax * d;
    end while (probe < n && common_len(i, probe, n) > dmin);
    l = 0;
    for (t = lmax >> 1; t > 0; t = t >> 1) begin
      probe = i + (l + t) * d;
      if (common_len(i, probe, n) > dmin) l += t;
    end
    j = i + l * d;
    dnode = common_len(i, j, n);
    s = 0;
    t = l;
    do begin
      t = (t + 1) >> 1;
      probe = i + (s + t) * d;
      if (common_len(i, probe, n) > dnode) s += t;
    end while (t > 1);
    k = i + s * d + (d < 0 ? -1 : 0);
    lo = i < j ? i : j;
    hi = i < j ? j : i;
    r.left = k[IDX_W-1:0];
    r.left_leaf = (lo == k);
    r.right = IDX_W'(k + 1);
    r.right_leaf = (hi == k + 1);
    return r;
  endfunction

  always @(posedge clk) begin
    split_t exp_r, got;
    if (!rst_n) begin
      leaf_cnt <= 11'd2;
      split_q.delete();
      err_count <= 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        got = '{out_node_index, out_left_child, out_left_is_leaf, out_right_child,
                out_right_is_leaf, out_bad_node};
        if (split_q.size() == 0) begin
          if (err_count < 10)
            $display("unexpected result: node %0d", out_node_index);
          err_count <= err_count + 1;
        end else begin
          exp_r = split_q.pop_front();
          if (got !== exp_r) begin
            if (err_count < 10) begin
              $display("mismatch exp: node %0d L=%0d/%0b R=%0d/%0b bad=%0b",
                       exp_r.node, exp_r.left, exp_r.left_leaf, exp_r.right,
                       exp_r.right_leaf, exp_r.bad);
              $display("         got: node %0d L=%0d/%0b R=%0d/%0b bad=%0b",
                       got.node, got.left, got.left_leaf, got.right,
                       got.right_leaf, got.bad);
            end
            err_count <= err_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (in_func == FUNC_LOAD) begin
          codes[in_index] = in_leaf_code;
          ids[in_index] = in_leaf_id;
        end else begin
          split_q.insert(split_q.size(), split_node(in_index));
        end
      end
      if (cfg_we) leaf_cnt <= cfg_data;
      pending <= split_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// top of the radix_tree_node_split_core testbench: clock, reset, item and
// register stimulus, verdict; depends on rtns_pkg, radix_tree_node_split_core and rtns_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rtns_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_func = 1'b0;
  logic [IDX_W-1:0] in_index = '0;
  logic [CODE_IN_W-1:0] in_leaf_code = '0;
  logic [ID_W-1:0] in_leaf_id = '0;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic out_valid, out_left_is_leaf, out_right_is_leaf, out_bad_node;
  logic [IDX_W-1:0] out_node_index, out_left_child, out_right_child;
  int err_count, pending;
  int cycles = 0;
  int sent = 0;
  bit idle_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  radix_tree_node_split_core dut (.*);

  rtns_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(bit f, logic [IDX_W-1:0] idx, logic [31:0] code, logic [ID_W-1:0] id);
    bit acc;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_func = f;
    in_index = idx;
    in_leaf_code = code;
    in_leaf_id = id;
    start = 1'b1;
    do begin
      @(posedge clk);
      acc = !busy;
    end while (!acc);
    sent++;
  endtask

  task automatic set_leaves(logic [CNT_W-1:0] v);
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_data = v;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // sorted codes with frequent duplicates and repeated ids
  task automatic load_sorted(int n);
    logic [31:0] vals[$];
    logic [31:0] pool[4];
    logic [ID_W-1:0] id;
    foreach (pool[p]) pool[p] = $urandom();
    for (int q = 0; q < n; q++)
      vals.insert(vals.size(),
                  $urandom_range(0, 2) == 0 ? pool[$urandom_range(0, 3)] : $urandom());
    vals.sort();
    for (int q = 0; q < n; q++) begin
      if (q == 0 || $urandom_range(0, 4) != 0) id = ID_W'($urandom());
      send(FUNC_LOAD, IDX_W'(q), vals[q], id);
    end
  endtask

  task automatic node_burst(int n, int cnt);
    for (int q = 0; q < cnt; q++) begin
      case ($urandom_range(0, 9))
        0: send(FUNC_NODE, IDX_W'($urandom()), 32'h0, 10'h0);
        1: send(FUNC_LOAD, IDX_W'($urandom()), $urandom(), ID_W'($urandom()));
        default: send(FUNC_NODE, IDX_W'($urandom_range(0, n - 1)), $urandom(),
                      ID_W'($urandom()));
      endcase
    end
  endtask

  initial begin
    int n;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    // two leaves, same code and same id
    send(FUNC_LOAD, 10'd0, 32'hFFFF_FFFF, 10'h3FF);
    send(FUNC_LOAD, 10'd1, 32'hFFFF_FFFF, 10'h3FF);
    send(FUNC_NODE, 10'd0, 32'h0, 10'h0);
    send(FUNC_NODE, 10'd1, 32'h0, 10'h0);
    send(FUNC_NODE, 10'h3FF, 32'h0, 10'h0);
    // same code, ids differ
    send(FUNC_LOAD, 10'd1, 32'hFFFF_FFFF, 10'h000);
    send(FUNC_NODE, 10'd0, 32'h0, 10'h0);
    // four equal leaves, ties send the search downward
    set_leaves(11'd4);
    for (int q = 0; q < 4; q++) send(FUNC_LOAD, IDX_W'(q), 32'h0, 10'h155);
    for (int q = 0; q < 4; q++) send(FUNC_NODE, IDX_W'(q), 32'h0, 10'h0);
    // no valid node
    set_leaves(11'd0);
    send(FUNC_NODE, 10'd0, 32'h0, 10'h0);
    set_leaves(11'd1);
    send(FUNC_NODE, 10'd0, 32'h0, 10'h0);
    // full store, then saturated count
    set_leaves(11'd1024);
    load_sorted(1024);
    node_burst(1024, 20);
    send(FUNC_NODE, 10'd1022, 32'h0, 10'h0);
    send(FUNC_NODE, 10'd1023, 32'h0, 10'h0);
    set_leaves(11'h7FF);
    node_burst(1024, 15);
    while (sent < 1250) begin
      if (sent > 1150) idle_on = 1'b0;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 120) : $urandom_range(2, 24);
      set_leaves(CNT_W'(n));
      load_sorted(n);
      node_burst(n, $urandom_range(15, 40));
    end
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
